// File: design/evad_pkg.sv
// Shared types and constants for the energy voice activity detector.
`timescale 1ns / 1ps

package evad_pkg;

  localparam int unsigned LevelWidth = 16;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_ONSET_THRESHOLD   = 2'd0,
    REG_RELEASE_THRESHOLD = 2'd1,
    REG_MIN_ONSET_TICKS   = 2'd2,
    REG_HANGOVER_TICKS    = 2'd3
  } reg_index_t;

  typedef enum logic {
    KIND_ONSET = 1'b0,
    KIND_END   = 1'b1
  } event_kind_t;

  typedef struct packed {
    logic [LevelWidth-1:0] onset_threshold;
    logic [LevelWidth-1:0] release_threshold;
    logic [TimeWidth-1:0]  min_onset_ticks;
    logic [TimeWidth-1:0]  hangover_ticks;
  } cfg_t;

  typedef struct packed {
    logic                 speaking;
    logic                 onset_armed;
    logic                 hangover_running;
    logic [TimeWidth-1:0] onset_start_time;
    logic [TimeWidth-1:0] quiet_start_time;
  } vad_state_t;

  typedef struct packed {
    logic        fire;
    event_kind_t kind;
  } decision_t;

endpackage

// File: design/evad_decide.sv
// Per-frame decision: next detector state and boundary event.
`timescale 1ns / 1ps

module evad_decide (
  input  evad_pkg::cfg_t                       cfg,
  input  evad_pkg::vad_state_t                 state,
  input  logic [evad_pkg::LevelWidth-1:0]      level,
  input  logic [evad_pkg::TimeWidth-1:0]       timestamp,
  output evad_pkg::vad_state_t                 state_next,
  output evad_pkg::decision_t                  decision
);

  logic                           loud_onset;
  logic                           loud_release;
  logic [evad_pkg::TimeWidth-1:0] quiet_start;
  logic [evad_pkg::TimeWidth-1:0] onset_elapsed;
  logic [evad_pkg::TimeWidth-1:0] quiet_elapsed;

  assign loud_onset    = (level >= cfg.onset_threshold);
  assign loud_release  = (level >= cfg.release_threshold);
  // hangover is timed from the first quiet frame, which may be this one
  assign quiet_start   = state.hangover_running ? state.quiet_start_time : timestamp;
  assign onset_elapsed = timestamp - state.onset_start_time;
  assign quiet_elapsed = timestamp - quiet_start;

  always_comb begin
    state_next    = state;
    decision.fire = 1'b0;
    decision.kind = evad_pkg::KIND_ONSET;
    if (!state.speaking) begin
      if (loud_onset) begin
        if (!state.onset_armed) begin
          state_next.onset_armed      = 1'b1;
          state_next.onset_start_time = timestamp;
        end else if (onset_elapsed >= cfg.min_onset_ticks) begin
          state_next.speaking         = 1'b1;
          state_next.onset_armed      = 1'b0;
          state_next.hangover_running = 1'b0;
          decision.fire               = 1'b1;
          decision.kind               = evad_pkg::KIND_ONSET;
        end
      end else begin
        state_next.onset_armed = 1'b0;
      end
    end else if (loud_release) begin
      state_next.hangover_running = 1'b0;
    end else begin
      state_next.hangover_running = 1'b1;
      state_next.quiet_start_time = quiet_start;
      if (quiet_elapsed >= cfg.hangover_ticks) begin
        state_next.speaking         = 1'b0;
        state_next.onset_armed      = 1'b0;
        state_next.hangover_running = 1'b0;
        decision.fire               = 1'b1;
        decision.kind               = evad_pkg::KIND_END;
      end
    end
  end

endmodule

// File: design/energy_voice_activity_detector.sv
// Path from input transfer to result valid: input register, then result register.
// Throughput: one frame per cycle; a frame that fires stalls only while the result waits.
// The detector state updates as each frame leaves the input register.
// Reset (rst, synchronous): silent, no candidate, no hangover, all thresholds and
// durations zero, both pipeline registers empty.
`timescale 1ns / 1ps

module energy_voice_activity_detector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [evad_pkg::CfgIdxWidth-1:0]    cfg_index,
  input  logic [evad_pkg::CfgDataWidth-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [evad_pkg::LevelWidth-1:0]     level,
  input  logic [evad_pkg::TimeWidth-1:0]      timestamp,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                event_kind,
  output logic [evad_pkg::TimeWidth-1:0]      event_time,
  output logic [evad_pkg::LevelWidth-1:0]     event_level
);

  evad_pkg::cfg_t                 cfg;
  evad_pkg::vad_state_t           state;
  evad_pkg::vad_state_t           state_next;
  evad_pkg::decision_t            decision;

  logic                           frame_valid;
  logic [evad_pkg::LevelWidth-1:0] frame_level;
  logic [evad_pkg::TimeWidth-1:0]  frame_time;
  logic                           frame_advance;
  logic                           result_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (evad_pkg::reg_index_t'(cfg_index))
        evad_pkg::REG_ONSET_THRESHOLD:
          cfg.onset_threshold <= cfg_data[evad_pkg::LevelWidth-1:0];
        evad_pkg::REG_RELEASE_THRESHOLD:
          cfg.release_threshold <= cfg_data[evad_pkg::LevelWidth-1:0];
        evad_pkg::REG_MIN_ONSET_TICKS:
          cfg.min_onset_ticks <= cfg_data[evad_pkg::TimeWidth-1:0];
        evad_pkg::REG_HANGOVER_TICKS:
          cfg.hangover_ticks <= cfg_data[evad_pkg::TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  evad_decide u_decide (
    .cfg        (cfg),
    .state      (state),
    .level      (frame_level),
    .timestamp  (frame_time),
    .state_next (state_next),
    .decision   (decision)
  );

  // a frame without an event never waits on the result register
  assign frame_advance = frame_valid && (!decision.fire || !out_valid || out_ready);
  assign result_load   = frame_advance && decision.fire;
  assign in_ready      = !frame_valid || frame_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (in_ready) begin
      frame_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_level <= level;
      frame_time  <= timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (frame_advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      event_kind  <= decision.kind;
      event_time  <= frame_time;
      event_level <= frame_level;
    end
  end

  // speech is only entered through an onset event
  a_onset_event: assert property (@(posedge clk) disable iff (rst)
    $rose(state.speaking) |-> $past(result_load && decision.kind == evad_pkg::KIND_ONSET))
    else $error("speaking set without onset event");

  a_silent_no_hangover: assert property (@(posedge clk) disable iff (rst)
    !state.speaking |-> !state.hangover_running)
    else $error("hangover running while silent");

  a_speaking_no_candidate: assert property (@(posedge clk) disable iff (rst)
    state.speaking |-> !state.onset_armed)
    else $error("onset candidate armed during speech");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !result_load)
    else $error("pending result overwritten");

endmodule

// File: tb/sv/tb_energy_voice_activity_detector.sv
// Self-checking testbench for the energy voice activity detector.
`timescale 1ns / 1ps

module tb_energy_voice_activity_detector;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 6;

  typedef logic [evad_pkg::LevelWidth-1:0]   level_t;
  typedef logic [evad_pkg::TimeWidth-1:0]    tick_t;
  typedef logic [evad_pkg::CfgDataWidth-1:0] cfg_word_t;

  typedef struct {
    evad_pkg::event_kind_t kind;
    tick_t                 stamp;
    level_t                lvl;
  } boundary_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [evad_pkg::CfgIdxWidth-1:0]    cfg_index = '0;
  cfg_word_t                           cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  level_t                              level = '0;
  tick_t                               timestamp = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b1;
  logic                                event_kind;
  tick_t                               event_time;
  level_t                              event_level;

  energy_voice_activity_detector u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .level      (level),
    .timestamp  (timestamp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .event_time (event_time),
    .event_level(event_level)
  );

  // Shadow of the detector: thresholds, durations and state
  level_t onset_thr, release_thr;
  tick_t  min_onset, hangover;
  logic   speaking, armed, hang_run;
  tick_t  onset_t, quiet_t;

  boundary_t pending_events[$];

  int mismatch_count = 0;
  int frames_sent    = 0;
  int settings_used  = 0;
  int onsets_seen    = 0;
  int ends_seen      = 0;
  int cycle_count    = 0;
  int stall_left     = 0;
  int stall_odds     = 0;
  bit gaps_on        = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver stalls in bursts of random length
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    boundary_t exp_ev;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected event kind=%0d time=%h level=%h",
                                event_kind, event_time, event_level));
      end else begin
        exp_ev = pending_events[0];
        pending_events.delete(0);
        if (event_kind !== exp_ev.kind)
          flag_mismatch($sformatf("event_kind %0d, expected %0d", event_kind, exp_ev.kind));
        if (event_time !== exp_ev.stamp)
          flag_mismatch($sformatf("event_time %h, expected %h", event_time, exp_ev.stamp));
        if (event_level !== exp_ev.lvl)
          flag_mismatch($sformatf("event_level %h, expected %h", event_level, exp_ev.lvl));
        if (exp_ev.kind == evad_pkg::KIND_ONSET) onsets_seen++;
        else ends_seen++;
      end
    end
  end

  function automatic void queue_boundary(input evad_pkg::event_kind_t kind, input tick_t now,
                                         input level_t lvl);
    boundary_t ev;
    ev.kind  = kind;
    ev.stamp = now;
    ev.lvl   = lvl;
    pending_events.insert(pending_events.size(), ev);
  endfunction

  // Onset debounce while silent, hangover while speaking; elapsed times wrap mod 2^32
  function automatic void predict_boundary(input level_t lvl, input tick_t now);
    tick_t elapsed;
    if (!speaking) begin
      if (lvl >= onset_thr) begin
        elapsed = now - onset_t;
        if (!armed) begin
          armed   = 1'b1;
          onset_t = now;
        end else if (elapsed >= min_onset) begin
          speaking = 1'b1;
          armed    = 1'b0;
          hang_run = 1'b0;
          queue_boundary(evad_pkg::KIND_ONSET, now, lvl);
        end
      end else begin
        armed = 1'b0;
      end
    end else if (lvl >= release_thr) begin
      hang_run = 1'b0;
    end else begin
      if (!hang_run) begin
        hang_run = 1'b1;
        quiet_t  = now;
      end
      elapsed = now - quiet_t;
      if (elapsed >= hangover) begin
        speaking = 1'b0;
        armed    = 1'b0;
        hang_run = 1'b0;
        queue_boundary(evad_pkg::KIND_END, now, lvl);
      end
    end
  endfunction

  task automatic send_frame(input level_t lvl, input tick_t ts);
    int gap;
    gap = (gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    level     = lvl;
    timestamp = ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_boundary(lvl, ts);
    frames_sent++;
  endtask

  task automatic cfg_write(input evad_pkg::reg_index_t idx, input cfg_word_t data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      evad_pkg::REG_ONSET_THRESHOLD:   onset_thr   = data[evad_pkg::LevelWidth-1:0];
      evad_pkg::REG_RELEASE_THRESHOLD: release_thr = data[evad_pkg::LevelWidth-1:0];
      evad_pkg::REG_MIN_ONSET_TICKS:   min_onset   = data;
      evad_pkg::REG_HANGOVER_TICKS:    hangover    = data;
      default: ;
    endcase
  endtask

  task automatic drain_events();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    // frames that raise no event may still be in flight
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Upper data bits above a threshold's width are junk and must be dropped
  task automatic apply_settings(input level_t on_thr,
                                input level_t rel_thr,
                                input tick_t min_ticks,
                                input tick_t hang_ticks);
    drain_events();
    cfg_write(evad_pkg::REG_ONSET_THRESHOLD,   {16'($urandom), on_thr});
    cfg_write(evad_pkg::REG_RELEASE_THRESHOLD, {16'($urandom), rel_thr});
    cfg_write(evad_pkg::REG_MIN_ONSET_TICKS,   min_ticks);
    cfg_write(evad_pkg::REG_HANGOVER_TICKS,    hang_ticks);
    @(negedge clk);
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  function automatic level_t pick_level(input bit loud);
    level_t lo, hi;
    lo = (onset_thr > release_thr) ? onset_thr : release_thr;
    hi = (onset_thr < release_thr) ? onset_thr : release_thr;
    if (loud) return level_t'($urandom_range(16'hFFFF, lo));
    if (hi == 0) return level_t'($urandom);
    return level_t'($urandom_range(hi - 1, 0));
  endfunction

  // All registers zero: two frames make an onset and speech never ends
  task automatic test_reset_defaults();
    send_frame(16'h0000, 32'h0000_0000);
    send_frame(16'h0000, 32'h0000_0000);
    send_frame(16'h0000, 32'h0000_0005);
    send_frame(16'hFFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_onset_and_hangover();
    apply_settings(16'h8000, 16'h4000, 32'd10, 32'd5);
    // speaking from the previous test: hangover, cleared, restarted, then end
    send_frame(16'h3FFF, 32'd100);
    send_frame(16'h4000, 32'd102);
    send_frame(16'h0000, 32'd103);
    send_frame(16'h1234, 32'd107);
    send_frame(16'h0001, 32'd108);
    // candidate across the timestamp wrap: 9 ticks short, then exactly 10
    send_frame(16'hFFFF, 32'hFFFF_FFFA);
    send_frame(16'h8000, 32'h0000_0003);
    send_frame(16'h8000, 32'h0000_0004);
    // quiet frame in speech with zero hangover ends at once
    apply_settings(16'h8000, 16'h4000, 32'd10, 32'd0);
    send_frame(16'h3FFF, 32'd50);
    // quiet frame cancels a candidate; a backward timestamp reads as a long delay
    send_frame(16'hFFFF, 32'd200);
    send_frame(16'h7FFF, 32'd201);
    send_frame(16'h8000, 32'd300);
    send_frame(16'h9000, 32'd309);
    send_frame(16'h8001, 32'd250);
  endtask

  task automatic test_wrap_and_extremes();
    apply_settings(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_frame(16'hFFFF, 32'h0000_0005);
    send_frame(16'hFFFF, 32'h0000_0004);
    send_frame(16'hFFFE, 32'h0000_0000);
    send_frame(16'hFFFF, 32'h0000_0010);
    send_frame(16'h0000, 32'h0000_0000);
    send_frame(16'h0000, 32'hFFFF_FFFF);
  endtask

  // Runs of loud and quiet frames paced around the durations, with some noise
  task automatic run_traffic(input int frames);
    tick_t now;
    tick_t span;
    int    run_left;
    bit    loud;
    int    k;
    now      = $urandom;
    run_left = 0;
    loud     = 1'($urandom_range(0, 1));
    span     = (min_onset > hangover) ? min_onset : hangover;
    span     = (span > 1000) ? 32'd40 : span / 3 + 2;
    for (k = 0; k < frames; k++) begin
      if (run_left == 0) begin
        loud     = !loud;
        run_left = $urandom_range(1, 10);
      end
      run_left--;
      if ($urandom_range(0, 9) == 0) begin
        send_frame(level_t'($urandom), $urandom);
      end else begin
        if ($urandom_range(0, 30) == 0) now = now + $urandom;
        else now = now + $urandom_range(0, span);
        send_frame(pick_level(loud), now);
      end
    end
  endtask

  task automatic test_random_phases();
    level_t on_thr, rel_thr;
    tick_t  min_ticks, hang_ticks;
    int p;
    for (p = 0; p < 8; p++) begin
      on_thr     = level_t'($urandom);
      rel_thr    = level_t'($urandom);
      min_ticks  = $urandom_range(0, 40);
      hang_ticks = $urandom_range(0, 40);
      case (p)
        2: begin
          on_thr  = 16'h0000;
          rel_thr = 16'hFFFF;
        end
        3: begin
          on_thr     = 16'hFFFF;
          rel_thr    = 16'h0000;
          min_ticks  = 32'd0;
          hang_ticks = 32'd0;
        end
        5: begin
          min_ticks  = 32'hFFFF_FFFF;
          hang_ticks = $urandom;
        end
        default: ;
      endcase
      apply_settings(on_thr, rel_thr, min_ticks, hang_ticks);
      if (p >= 6) begin
        gaps_on    = 1'b0;
        stall_odds = 0;
        stall_left = 0;
      end else begin
        gaps_on    = (p != 1);
        stall_odds = (p == 4) ? 0 : $urandom_range(2, 6);
      end
      run_traffic(50);
    end
  endtask

  initial begin
    onset_thr   = '0;
    release_thr = '0;
    min_onset   = '0;
    hangover    = '0;
    speaking    = 1'b0;
    armed       = 1'b0;
    hang_run    = 1'b0;
    onset_t     = '0;
    quiet_t     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    gaps_on    = 1'b1;
    stall_odds = 4;
    test_reset_defaults();
    test_onset_and_hangover();
    test_wrap_and_extremes();
    test_random_phases();

    drain_events();
    $display("Sent %0d frames under %0d register settings", frames_sent, settings_used);
    $display("Checked %0d onset and %0d end events", onsets_seen, ends_seen);
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
